/* hw/rtl/rbra_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbra_pkg
// Shared widths, codes and datapath control types for the recent-average ring.
// ----------------------------------------------------------------------------
package rbra_pkg;

  localparam int VALUE_W   = 32;               // Q23.8 sample and mean
  localparam int NS_W      = 30;               // nanoseconds field
  localparam int COUNT_W   = 7;                // window and used count
  localparam int SUM_W     = VALUE_W + COUNT_W; // exact sum of up to 127 samples
  localparam int DEPTH_DEF = 64;

  // -1.0 in Q23.8
  localparam logic [VALUE_W-1:0] MINUS_ONE_Q8 = 32'hFFFF_FF00;

  // item kinds
  localparam logic KIND_APPEND = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  // shared unit operations
  typedef logic [2:0] op_t;
  localparam op_t OP_HOLD  = 3'd0;
  localparam op_t OP_CLEAR = 3'd1;
  localparam op_t OP_ADD   = 3'd2;
  localparam op_t OP_ABS   = 3'd3;
  localparam op_t OP_DIV   = 3'd4;
  localparam op_t OP_SIGN  = 3'd5;

  typedef struct packed {
    op_t                op;
    logic [COUNT_W-1:0] divisor;
  } dp_ctl_t;

endpackage
`default_nettype wire

/* hw/rtl/rbra_store.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbra_store
// Sample memory: one write port, one registered read port. Each word holds
// the entry's valid flag above its value.
// ----------------------------------------------------------------------------
module rbra_store
  import rbra_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  localparam int PW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [PW-1:0]    waddr,
  input  wire logic [VALUE_W:0] wdata,
  input  wire logic [PW-1:0]    raddr,
  output logic      [VALUE_W:0] rdata
);

  logic [VALUE_W:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* hw/rtl/rbra_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbra_datapath
// Accumulator and restoring divider around one shared add/subtract unit.
// The accumulator holds the sum, then its magnitude, then the quotient, then the signed mean.
// ----------------------------------------------------------------------------
module rbra_datapath
  import rbra_pkg::*;
(
  input  wire logic                      clk,
  input  wire dp_ctl_t                   ctl,
  input  wire logic signed [VALUE_W-1:0] rd_value,
  output logic             [VALUE_W-1:0] quot
);

  localparam int AW = SUM_W + 1;

  logic [SUM_W-1:0]   acc;
  logic [COUNT_W-1:0] rem;
  logic               neg;

  logic [AW-1:0] op_a;
  logic [AW-1:0] op_b;
  logic          sub;
  logic [AW-1:0] res;
  logic [COUNT_W:0] shifted;

  assign shifted = {rem, acc[SUM_W-1]};

  // operand select for the shared adder
  always_comb begin
    op_a = '0;
    op_b = '0;
    sub  = 1'b0;
    case (ctl.op)
      OP_ADD: begin
        op_a = {acc[SUM_W-1], acc};
        op_b = AW'(rd_value);
      end
      OP_ABS, OP_SIGN: begin
        op_b = {acc[SUM_W-1], acc};
        sub  = 1'b1;
      end
      OP_DIV: begin
        op_a = AW'(shifted);
        op_b = AW'(ctl.divisor);
        sub  = 1'b1;
      end
      default: begin
        op_a = '0;
      end
    endcase
  end

  assign res = op_a + (sub ? ~op_b : op_b) + AW'(sub);

  // register update
  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_CLEAR: begin
        acc <= '0;
        rem <= '0;
        neg <= 1'b0;
      end
      OP_ADD: begin
        acc <= res[SUM_W-1:0];
      end
      OP_ABS: begin
        neg <= acc[SUM_W-1];
        rem <= '0;
        if (acc[SUM_W-1]) begin
          acc <= res[SUM_W-1:0];
        end
      end
      OP_DIV: begin
        // borrow clear: divisor fits, set quotient bit
        if (!res[AW-1]) begin
          rem <= res[COUNT_W-1:0];
          acc <= {acc[SUM_W-2:0], 1'b1};
        end else begin
          rem <= shifted[COUNT_W-1:0];
          acc <= {acc[SUM_W-2:0], 1'b0};
        end
      end
      OP_SIGN: begin
        if (neg) begin
          acc <= res[SUM_W-1:0];
        end
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

  assign quot = acc[VALUE_W-1:0];

endmodule
`default_nettype wire

/* hw/rtl/ring_buffer_recent_average_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ring_buffer_recent_average_top
// Ring of timed Q23.8 samples with a mean over the most recent entries.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one word per item. kind selects
// append or query. An append with an all-zero timestamp is dropped; otherwise
// it is written at the write pointer, marked empty if seconds are negative,
// and gives no result.
// A query walks back over min(window_count, DEPTH) slots, one memory read per
// cycle, then divides the sum by the number of live entries found, one
// quotient bit per cycle on the shared adder. in_ready is low from the query
// until its result word is loaded into the output register.
// The result word (mean_value, used_count, none_found) sits in an output
// register on out_valid/out_ready. Appends keep being taken while it waits;
// a following query finishes its work and then holds until the word is taken.
// Reset clears the write pointer, the fill count and the output valid. Slots
// not written since reset read as empty through the fill count, so no
// clearing pass is needed and the block is ready right after reset.
// ----------------------------------------------------------------------------
module ring_buffer_recent_average_top
  import rbra_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      kind,
  input  wire logic signed [VALUE_W-1:0] sample_value,
  input  wire logic signed [VALUE_W-1:0] stamp_seconds,
  input  wire logic        [NS_W-1:0]    stamp_nanoseconds,
  input  wire logic        [COUNT_W-1:0] window_count,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic signed      [VALUE_W-1:0] mean_value,
  output logic             [COUNT_W-1:0] used_count,
  output logic                           none_found
);

  localparam int PW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_SIGN  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]         state;
  logic [PW-1:0]      wp;
  logic [FW-1:0]      fill;
  logic [FW-1:0]      avail;
  logic [PW-1:0]      rd_addr;
  logic [COUNT_W-1:0] cnt;
  logic [COUNT_W-1:0] used;
  logic               pend;
  logic               none;

  logic               in_acc;
  logic               do_append;
  logic [VALUE_W:0]   rdata;
  logic               take;
  dp_ctl_t            ctl;
  logic [VALUE_W-1:0] quot;

  assign in_ready  = (state == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign do_append = in_acc && (kind == KIND_APPEND)
                     && !((stamp_seconds == '0) && (stamp_nanoseconds == '0));
  // returned word from the slot issued last cycle counts
  assign take      = (state == S_WALK) && pend && rdata[VALUE_W];

  rbra_store #(.DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (do_append),
    .waddr (wp),
    .wdata ({!stamp_seconds[VALUE_W-1], sample_value}),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // shared unit control
  always_comb begin
    ctl.op      = OP_HOLD;
    ctl.divisor = used;
    unique case (state)
      S_IDLE: begin
        if (in_acc && (kind == KIND_QUERY)) ctl.op = OP_CLEAR;
      end
      S_WALK: begin
        if (take) ctl.op = OP_ADD;
      end
      S_CHECK: begin
        if (used != '0) ctl.op = OP_ABS;
      end
      S_DIV:  ctl.op = OP_DIV;
      S_SIGN: ctl.op = OP_SIGN;
      S_OUT:  ctl.op = OP_HOLD;
      default: ctl.op = OP_HOLD;
    endcase
  end

  rbra_datapath u_dp (
    .clk      (clk),
    .ctl      (ctl),
    .rd_value (rdata[VALUE_W-1:0]),
    .quot     (quot)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wp        <= '0;
      fill      <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // word taken; the output state loads its own word below
      if (out_valid && out_ready && (state != S_OUT)) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (do_append) begin
            wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + 1'b1;
            if (fill != FW'(DEPTH)) fill <= fill + 1'b1;
          end
          if (in_acc && (kind == KIND_QUERY)) begin
            cnt     <= (int'(window_count) > DEPTH) ? COUNT_W'(DEPTH) : window_count;
            rd_addr <= (wp == '0) ? PW'(DEPTH - 1) : wp - 1'b1;
            avail   <= fill;
            used    <= '0;
            pend    <= 1'b0;
            state   <= S_WALK;
          end
        end
        S_WALK: begin
          if (take) used <= used + 1'b1;
          if (cnt != '0) begin
            // issue the next older slot; written only if within the fill
            pend    <= (avail != '0);
            if (avail != '0) avail <= avail - 1'b1;
            rd_addr <= (rd_addr == '0) ? PW'(DEPTH - 1) : rd_addr - 1'b1;
            cnt     <= cnt - 1'b1;
          end else begin
            pend  <= 1'b0;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          none <= (used == '0);
          if (used == '0) begin
            state <= S_OUT;
          end else begin
            cnt   <= COUNT_W'(SUM_W);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          cnt <= cnt - 1'b1;
          if (cnt == COUNT_W'(1)) state <= S_SIGN;
        end
        S_SIGN: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            mean_value <= none ? MINUS_ONE_Q8 : quot;
            used_count <= used;
            none_found <= none;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_none_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (none_found == (used_count == '0)))
    else $error("none_found disagrees with used_count");

  a_none_mean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && none_found) |-> (mean_value == MINUS_ONE_Q8))
    else $error("empty result without -1.0 mean");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (kind == KIND_QUERY)) |=> !in_ready)
    else $error("query did not hold off the input");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (int'(fill) <= DEPTH) && (int'(avail) <= DEPTH || state == S_IDLE))
    else $error("fill count beyond depth");

endmodule
`default_nettype wire

/* bench/ring_buffer_recent_average_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_buffer_recent_average_top_tb
// Drives append and query words into the recent-average ring and checks every
// mean word against a cycle-free model of the ring held in a scoreboard.
// A short directed run covers empty windows, saturation and dropped appends;
// random traffic follows under three back-pressure profiles.
// ----------------------------------------------------------------------------
module ring_buffer_recent_average_top_tb;
  import rbra_pkg::*;

  localparam int RING_DEPTH  = DEPTH_DEF;
  localparam int PTR_W       = $clog2(RING_DEPTH);
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYC  = 150;

  typedef struct {
    logic signed [VALUE_W-1:0] mean;
    logic        [COUNT_W-1:0] used;
    logic                      none;
  } mean_word_t;

  // Scoreboard: mirror of the ring plus the queue of means still owed
  class mean_scoreboard;
    logic signed [VALUE_W-1:0] ring_value [RING_DEPTH];
    bit                        ring_live  [RING_DEPTH];
    logic [$clog2(RING_DEPTH)-1:0] wr_ptr = '0;
    mean_word_t                expected_means[$];
    int                        errors = 0;

    // mean over the most recent slots, empty slots skipped
    function mean_word_t window_mean(logic [COUNT_W-1:0] window);
      mean_word_t res;
      int         span;
      int         used;
      longint     sum;
      logic [$clog2(RING_DEPTH)-1:0] idx;
      span = (window > RING_DEPTH) ? RING_DEPTH : int'(window);
      used = 0;
      sum  = 0;
      for (int i = 0; i < span; i++) begin
        idx = PTR_W'(int'(wr_ptr) - 1 - i);
        if (ring_live[idx]) begin
          used++;
          sum += longint'(ring_value[idx]);
        end
      end
      if (used == 0) begin
        res.mean = MINUS_ONE_Q8;
        res.none = 1'b1;
      end else begin
        res.mean = VALUE_W'(sum / longint'(used));
        res.none = 1'b0;
      end
      res.used = COUNT_W'(used);
      return res;
    endfunction

    function void note_word(logic k, logic signed [VALUE_W-1:0] value,
                            logic signed [VALUE_W-1:0] secs,
                            logic [NS_W-1:0] nsecs, logic [COUNT_W-1:0] window);
      if (k == KIND_QUERY) begin
        expected_means.push_back(window_mean(window));
      end else if (secs != 0 || nsecs != 0) begin
        ring_value[wr_ptr] = value;
        ring_live[wr_ptr]  = (secs >= 0);
        wr_ptr++;
      end
    endfunction

    function void check_word(logic signed [VALUE_W-1:0] mean,
                             logic [COUNT_W-1:0] used, logic none);
      mean_word_t exp_w;
      if (expected_means.size() == 0) begin
        $error("mean word with no query pending: mean=%0d used=%0d none=%0b",
               mean, used, none);
        errors++;
        return;
      end
      exp_w = expected_means.pop_front();
      if (mean !== exp_w.mean) begin
        $error("mean_value: expected %0d, got %0d", exp_w.mean, mean);
        errors++;
      end
      if (used !== exp_w.used) begin
        $error("used_count: expected %0d, got %0d", exp_w.used, used);
        errors++;
      end
      if (none !== exp_w.none) begin
        $error("none_found: expected %0b, got %0b", exp_w.none, none);
        errors++;
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      kind = KIND_APPEND;
  logic signed [VALUE_W-1:0] sample_value = '0;
  logic signed [VALUE_W-1:0] stamp_seconds = '0;
  logic        [NS_W-1:0]    stamp_nanoseconds = '0;
  logic        [COUNT_W-1:0] window_count = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [VALUE_W-1:0] mean_value;
  logic        [COUNT_W-1:0] used_count;
  logic                      none_found;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycle_count   = 0;

  mean_scoreboard sb = new;

  ring_buffer_recent_average_top dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .kind             (kind),
    .sample_value     (sample_value),
    .stamp_seconds    (stamp_seconds),
    .stamp_nanoseconds(stamp_nanoseconds),
    .window_count     (window_count),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .mean_value       (mean_value),
    .used_count       (used_count),
    .none_found       (none_found)
  );

  always #1 clk = ~clk;

  // receiver back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // result capture
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_word(mean_value, used_count, none_found);
    end
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ring_buffer_recent_average_top_tb: errors");
      $finish;
    end
  end

  // one word on the input channel; entered and left at a falling edge
  task automatic send_word(input logic k, input logic [VALUE_W-1:0] value,
                           input logic [VALUE_W-1:0] secs,
                           input logic [NS_W-1:0] nsecs,
                           input logic [COUNT_W-1:0] window);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid          <= 1'b1;
    kind              <= k;
    sample_value      <= value;
    stamp_seconds     <= secs;
    stamp_nanoseconds <= nsecs;
    window_count      <= window;
    do @(posedge clk); while (!in_ready);
    sb.note_word(k, value, secs, nsecs, window);
    @(negedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return VALUE_W'($urandom_range(511)) - 32'd256;
      default: return $urandom;
    endcase
  endfunction

  // random word; dropped appends report not counted
  task automatic send_random(output bit counted);
    logic                 k;
    logic [VALUE_W-1:0]   secs;
    logic [NS_W-1:0]      nsecs;
    logic [COUNT_W-1:0]   window;
    int                   r;
    k = ($urandom_range(3) == 0) ? KIND_QUERY : KIND_APPEND;
    nsecs = ($urandom_range(9) == 0) ? NS_W'($urandom) : NS_W'($urandom_range(999999999));
    r = $urandom_range(99);
    if (r < 70) begin
      secs = $urandom & 32'h7FFF_FFFF;
    end else if (r < 82) begin
      secs = $urandom | 32'h8000_0000;
    end else if (r < 92) begin
      secs  = '0;
      nsecs = '0;
    end else begin
      secs = '0;
      if (nsecs == 0) nsecs = NS_W'(1);
    end
    window = ($urandom_range(3) == 0) ? COUNT_W'($urandom_range(8))
                                      : COUNT_W'($urandom_range(127));
    counted = (k == KIND_QUERY) || (secs != 0) || (nsecs != 0);
    send_word(k, pick_value(), secs, nsecs, window);
  endtask

  task automatic run_phase(input int count);
    int  done;
    bit  counted;
    done = 0;
    while (done < count) begin
      send_random(counted);
      if (counted) done++;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty ring, extremes, dropped and empty-marked appends
    send_word(KIND_QUERY,  '0, '0, '0, 7'd0);
    send_word(KIND_QUERY,  '0, '0, '0, 7'd64);
    send_word(KIND_QUERY,  '0, '0, '0, 7'd127);
    send_word(KIND_APPEND, 32'h7FFF_FFFF, 32'd1, '0, 7'd127);
    send_word(KIND_APPEND, 32'h8000_0000, 32'd0, 30'd1, '0);
    send_word(KIND_APPEND, 32'd12345, 32'd0, 30'd0, '0);
    send_word(KIND_APPEND, 32'd1000, 32'hFFFF_FFFF, 30'd999999999, '0);
    send_word(KIND_APPEND, -32'sd257, 32'h7FFF_FFFF, 30'h3FFF_FFFF, '0);
    send_word(KIND_QUERY,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 30'h3FFF_FFFF, 7'd1);
    send_word(KIND_QUERY,  '0, '0, '0, 7'd2);
    send_word(KIND_QUERY,  '0, '0, '0, 7'd4);
    send_word(KIND_QUERY,  '0, '0, '0, 7'd65);
    send_word(KIND_APPEND, -32'sd1, 32'h8000_0000, 30'd5, '0);
    send_word(KIND_QUERY,  '0, '0, '0, 7'd1);
    send_word(KIND_APPEND, 32'h7FFF_FFFF, 32'd2, 30'd0, '0);
    send_word(KIND_APPEND, 32'h7FFF_FFFF, 32'd3, 30'd0, '0);
    send_word(KIND_QUERY,  '0, '0, '0, 7'd2);
    send_word(KIND_APPEND, 32'h8000_0000, 32'd4, 30'd0, '0);
    send_word(KIND_APPEND, 32'h8000_0000, 32'd5, 30'd0, '0);
    send_word(KIND_QUERY,  '0, '0, '0, 7'd2);
    send_word(KIND_QUERY,  '0, '0, '0, 7'd64);

    // random traffic under three back-pressure profiles
    send_idle_pct = 14;
    recv_idle_pct = 87;
    run_phase(630);
    send_idle_pct = 87;
    recv_idle_pct = 14;
    run_phase(630);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(640);
    in_valid <= 1'b0;

    // drain outstanding means, then let any stray word show up
    while (sb.expected_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);

    if (sb.errors == 0 && sb.expected_means.size() == 0) begin
      $display("ring_buffer_recent_average_top_tb: clean");
    end else begin
      $display("ring_buffer_recent_average_top_tb: errors");
    end
    $finish;
  end

endmodule
